// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked during reset too
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/thpid_pkg.sv =====
package thpid_pkg;

    localparam int TABLE_DEPTH_DEF      = 64;
    localparam int SAMPLES_PER_STEP_DEF = 16;

    localparam int OP_W        = 1;
    localparam int ENTRY_IDX_W = 6;
    localparam int ADC_W       = 12;
    localparam int TEMP_W      = 10;
    localparam int ELAPSED_W   = 16;
    localparam int DUTY_W      = 8;
    localparam int OUT_TEMP_W  = 18;
    localparam int ERR_W       = 20;
    localparam int ACC_W       = 32;
    localparam int GAIN_W      = 16;
    localparam int SETPOINT_W  = 8;
    localparam int COUNT_W     = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_MAG_W = DIV_NUM_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_MAG_W + 1);

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int RATE_SCALE = 1000;
    localparam int Q_SHIFT    = 8;
    localparam int DUTY_LSB   = 16;

    localparam logic [OP_W-1:0] OP_TABLE  = 1'b0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT        = 3'd0,
        REG_GAIN_P          = 3'd1,
        REG_GAIN_I          = 3'd2,
        REG_GAIN_D          = 3'd3,
        REG_INTEGRAL_WINDOW = 3'd4,
        REG_ENTRY_COUNT     = 3'd5
    } cfg_reg_t;

    localparam logic [SETPOINT_W-1:0] SETPOINT_RST = 8'd70;
    localparam logic [GAIN_W-1:0]     GAIN_P_RST   = 16'd2330;
    localparam logic [GAIN_W-1:0]     GAIN_I_RST   = 16'd77;
    localparam logic [GAIN_W-1:0]     GAIN_D_RST   = 16'd461;
    localparam logic [GAIN_W-1:0]     WINDOW_RST   = 16'd768;
    localparam logic [COUNT_W-1:0]    COUNT_RST    = 7'd64;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0]        den;
    } div_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

// ===== rtl/thpid_div.sv =====
module thpid_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  thpid_pkg::div_req_t req,
    output thpid_pkg::div_rsp_t rsp
);

    logic                                 busy_reg, busy_next;
    logic                                 done_reg, done_next;
    logic                                 neg_reg, neg_next;
    logic [thpid_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [thpid_pkg::DIV_DEN_W-1:0]      den_reg, den_next;
    logic [thpid_pkg::DIV_DEN_W-1:0]      rem_reg, rem_next;
    logic [thpid_pkg::DIV_MAG_W-1:0]      quo_reg, quo_next;
    logic [thpid_pkg::DIV_DEN_W:0]        trial;
    logic [thpid_pkg::DIV_NUM_W-1:0]      num_abs;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        num_abs   = req.num[thpid_pkg::DIV_NUM_W-1] ? -req.num : req.num;
        trial     = {rem_reg, quo_reg[thpid_pkg::DIV_MAG_W-1]};
        if (req.start) begin
            busy_next = 1'b1;
            neg_next  = req.num[thpid_pkg::DIV_NUM_W-1];
            cnt_next  = thpid_pkg::DIV_CNT_W'(thpid_pkg::DIV_MAG_W);
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = num_abs[thpid_pkg::DIV_MAG_W-1:0];
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = thpid_pkg::DIV_DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[thpid_pkg::DIV_MAG_W-2:0], 1'b1};
            end else begin
                rem_next = trial[thpid_pkg::DIV_DEN_W-1:0];
                quo_next = {quo_reg[thpid_pkg::DIV_MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == thpid_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

// ===== rtl/thermistor_pid_heater_control.sv =====
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    op, table entry, adc sample, elapsed_ms
// m_        out        m_valid / m_ready    duty, temperature
// cfg_      in         cfg_valid / cfg_ready register index, data (always ready)
//
// table writes and samples that do not close a step leave s_ready high; a closing
// sample holds it low for its whole control step: table entries are compared in
// turn, the average is a reciprocal multiply, interpolation and rate each take a
// pass of the shared divider; an average outside the table skips interpolation
// reset clears control state and loads register defaults; the table is not cleared
// a result waiting on m_ready holds the sequencer in its last state
module thermistor_pid_heater_control #(
    parameter int TABLE_DEPTH      = thpid_pkg::TABLE_DEPTH_DEF,
    parameter int SAMPLES_PER_STEP = thpid_pkg::SAMPLES_PER_STEP_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [thpid_pkg::OP_W-1:0]              s_op,
    input  logic [thpid_pkg::ENTRY_IDX_W-1:0]       s_entry_index,
    input  logic [thpid_pkg::ADC_W-1:0]             s_entry_adc,
    input  logic signed [thpid_pkg::TEMP_W-1:0]     s_entry_temp,
    input  logic [thpid_pkg::ADC_W-1:0]             s_adc_sample,
    input  logic [thpid_pkg::ELAPSED_W-1:0]         s_elapsed_ms,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [thpid_pkg::DUTY_W-1:0]            m_duty,
    output logic signed [thpid_pkg::OUT_TEMP_W-1:0] m_temperature,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [thpid_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [thpid_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = $clog2(SAMPLES_PER_STEP + 1);
    localparam int SW = thpid_pkg::ADC_W + CW;
    localparam int EW = thpid_pkg::ADC_W + thpid_pkg::TEMP_W;
    localparam int TW = thpid_pkg::TEMP_W;
    localparam int OW = thpid_pkg::OUT_TEMP_W;
    localparam int PW = thpid_pkg::PROD_W;
    localparam int ERW = thpid_pkg::ERR_W;
    localparam int AVG_SH = SW + $clog2(SAMPLES_PER_STEP);
    localparam logic [SW:0] AVG_M = (SW + 1)'(((64'd1 << AVG_SH) +
                                               64'(SAMPLES_PER_STEP) - 64'd1) /
                                              64'(SAMPLES_PER_STEP));

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_AVG_DIV  = 16'h0002,
        ST_SRCH_RD  = 16'h0004,
        ST_SRCH_CMP = 16'h0008,
        ST_INT_MUL  = 16'h0010,
        ST_INT_GO   = 16'h0020,
        ST_INT_DIV  = 16'h0040,
        ST_ERR      = 16'h0080,
        ST_P_MUL    = 16'h0100,
        ST_I_MUL    = 16'h0200,
        ST_I_ACC    = 16'h0400,
        ST_R_MUL    = 16'h0800,
        ST_R_GO     = 16'h1000,
        ST_R_DIV    = 16'h2000,
        ST_D_MUL    = 16'h4000,
        ST_SUM      = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [thpid_pkg::SETPOINT_W-1:0] setpoint_reg;
    logic [thpid_pkg::GAIN_W-1:0]     gain_p_reg, gain_i_reg, gain_d_reg, window_reg;
    logic [thpid_pkg::COUNT_W-1:0]    entry_count_reg;

    logic [EW-1:0] mem [TABLE_DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic          tbl_we;

    logic [SW-1:0]                       sum_reg, sum_next;
    logic [CW-1:0]                       count_reg, count_next;
    logic [thpid_pkg::ELAPSED_W-1:0]     elapsed_reg, elapsed_next;
    logic [thpid_pkg::ADC_W-1:0]         avg_reg, avg_next;
    logic [NW-1:0]                       k_reg, k_next, n_eff;
    logic [EW-1:0]                       prev_reg, prev_next;
    logic signed [TW-1:0]                t0_reg, t0_next;
    logic signed [OW-1:0]                temp_reg, temp_next;
    logic signed [ERW-1:0]               err_reg, err_next, last_err_reg, last_err_next;
    logic signed [thpid_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PW-1:0]                p_reg, p_next, prod_reg;
    logic signed [thpid_pkg::MUL_A_W-1:0] mul_a_reg, mul_a_next;
    logic signed [thpid_pkg::MUL_B_W-1:0] mul_b_reg, mul_b_next;
    logic                                div_go_reg, div_go_next;
    logic signed [thpid_pkg::DIV_NUM_W-1:0] div_num_reg, div_num_next;
    logic [thpid_pkg::DIV_DEN_W-1:0]     div_den_reg, div_den_next;
    logic                                m_valid_reg, m_valid_next;
    logic [thpid_pkg::DUTY_W-1:0]        duty_reg, duty_next;
    logic signed [OW-1:0]                out_temp_reg, out_temp_next;

    thpid_pkg::div_req_t div_req;
    thpid_pkg::div_rsp_t div_rsp;

    logic [thpid_pkg::ADC_W-1:0]     rd_adc, prev_adc;
    logic signed [TW-1:0]            rd_temp, prev_temp;
    logic signed [thpid_pkg::ADC_W:0] adc_diff;
    logic signed [TW:0]              temp_diff;
    logic [SW-1:0]                   sum_add;
    logic [2*SW:0]                   avg_prod;
    logic [ERW-1:0]                  err_mag;
    logic signed [ERW:0]             err_diff;
    logic signed [PW-1:0]            acc_sum, pid_sum;
    logic                            in_acc;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;
    assign tbl_we    = in_acc && (s_op == thpid_pkg::OP_TABLE) &&
                       (32'(s_entry_index) < TABLE_DEPTH);

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            mem[AW'(s_entry_index)] <= {s_entry_adc, s_entry_temp};
        end
        rd_data_reg <= mem[k_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg    <= thpid_pkg::SETPOINT_RST;
            gain_p_reg      <= thpid_pkg::GAIN_P_RST;
            gain_i_reg      <= thpid_pkg::GAIN_I_RST;
            gain_d_reg      <= thpid_pkg::GAIN_D_RST;
            window_reg      <= thpid_pkg::WINDOW_RST;
            entry_count_reg <= thpid_pkg::COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                thpid_pkg::REG_SETPOINT: begin
                    setpoint_reg <= cfg_data[thpid_pkg::SETPOINT_W-1:0];
                end
                thpid_pkg::REG_GAIN_P:          gain_p_reg <= cfg_data;
                thpid_pkg::REG_GAIN_I:          gain_i_reg <= cfg_data;
                thpid_pkg::REG_GAIN_D:          gain_d_reg <= cfg_data;
                thpid_pkg::REG_INTEGRAL_WINDOW: window_reg <= cfg_data;
                thpid_pkg::REG_ENTRY_COUNT: begin
                    entry_count_reg <= cfg_data[thpid_pkg::COUNT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a_reg * mul_b_reg;
    end

    assign div_req.start = div_go_reg;
    assign div_req.num   = div_num_reg;
    assign div_req.den   = div_den_reg;

    thpid_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        if (entry_count_reg == '0) begin
            n_eff = NW'(1);
        end else if (32'(entry_count_reg) > TABLE_DEPTH) begin
            n_eff = NW'(TABLE_DEPTH);
        end else begin
            n_eff = NW'(entry_count_reg);
        end
    end

    assign rd_adc    = rd_data_reg[EW-1:TW];
    assign rd_temp   = $signed(rd_data_reg[TW-1:0]);
    assign prev_adc  = prev_reg[EW-1:TW];
    assign prev_temp = $signed(prev_reg[TW-1:0]);
    assign adc_diff  = $signed({1'b0, avg_reg}) - $signed({1'b0, prev_adc});
    assign temp_diff = (TW + 1)'(rd_temp) - (TW + 1)'(prev_temp);
    assign sum_add   = sum_reg + SW'(s_adc_sample);
    // average by reciprocal multiply, exact for every sum that fits SW bits
    assign avg_prod  = (2 * SW + 1)'(div_num_reg[SW-1:0]) * (2 * SW + 1)'(AVG_M);
    assign err_mag   = err_reg[ERW-1] ? ERW'(-err_reg) : ERW'(err_reg);
    assign err_diff  = (ERW + 1)'(err_reg) - (ERW + 1)'(last_err_reg);
    assign acc_sum   = PW'(acc_reg) + prod_reg;
    assign pid_sum   = p_reg + PW'(acc_reg) + prod_reg;

    always_comb begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        elapsed_next  = elapsed_reg;
        avg_next      = avg_reg;
        k_next        = k_reg;
        prev_next     = prev_reg;
        t0_next       = t0_reg;
        temp_next     = temp_reg;
        err_next      = err_reg;
        last_err_next = last_err_reg;
        acc_next      = acc_reg;
        p_next        = p_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        div_go_next   = 1'b0;
        div_num_next  = div_num_reg;
        div_den_next  = div_den_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        duty_next     = duty_reg;
        out_temp_next = out_temp_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && (s_op == thpid_pkg::OP_SAMPLE)) begin
                    if (count_reg == CW'(SAMPLES_PER_STEP - 1)) begin
                        sum_next     = '0;
                        count_next   = '0;
                        elapsed_next = s_elapsed_ms;
                        div_num_next = thpid_pkg::DIV_NUM_W'(sum_add);
                        state_next   = ST_AVG_DIV;
                    end else begin
                        sum_next   = sum_add;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_AVG_DIV: begin
                avg_next   = avg_prod[AVG_SH +: thpid_pkg::ADC_W];
                k_next     = '0;
                state_next = ST_SRCH_RD;
            end
            ST_SRCH_RD: state_next = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                if (rd_adc < avg_reg) begin
                    if (k_reg + 1'b1 == n_eff) begin
                        temp_next  = {rd_temp, {thpid_pkg::Q_SHIFT{1'b0}}};
                        state_next = ST_ERR;
                    end else begin
                        prev_next  = rd_data_reg;
                        k_next     = k_reg + 1'b1;
                        state_next = ST_SRCH_RD;
                    end
                end else if (k_reg == '0) begin
                    temp_next  = {rd_temp, {thpid_pkg::Q_SHIFT{1'b0}}};
                    state_next = ST_ERR;
                end else begin
                    mul_a_next   = thpid_pkg::MUL_A_W'(adc_diff);
                    mul_b_next   = thpid_pkg::MUL_B_W'(temp_diff);
                    t0_next      = prev_temp;
                    div_den_next = thpid_pkg::DIV_DEN_W'(rd_adc - prev_adc);
                    state_next   = ST_INT_MUL;
                end
            end
            ST_INT_MUL: state_next = ST_INT_GO;
            ST_INT_GO: begin
                div_go_next  = 1'b1;
                div_num_next = {prod_reg[24:0], {thpid_pkg::Q_SHIFT{1'b0}}};
                state_next   = ST_INT_DIV;
            end
            ST_INT_DIV: begin
                if (div_rsp.done) begin
                    temp_next  = {t0_reg, {thpid_pkg::Q_SHIFT{1'b0}}} + div_rsp.quo[OW-1:0];
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                err_next   = $signed({{(ERW - thpid_pkg::SETPOINT_W - thpid_pkg::Q_SHIFT){1'b0}},
                                      setpoint_reg, {thpid_pkg::Q_SHIFT{1'b0}}})
                             - ERW'(temp_reg);
                mul_a_next = thpid_pkg::MUL_A_W'(err_next);
                mul_b_next = $signed({1'b0, gain_p_reg});
                state_next = ST_P_MUL;
            end
            ST_P_MUL: begin
                mul_b_next = $signed({1'b0, gain_i_reg});
                state_next = ST_I_MUL;
            end
            ST_I_MUL: begin
                p_next     = prod_reg;
                state_next = ST_I_ACC;
            end
            ST_I_ACC: begin
                if ({{(ERW - thpid_pkg::GAIN_W){1'b0}}, window_reg} > err_mag) begin
                    if (acc_sum[PW-1:thpid_pkg::ACC_W-1] == '0 ||
                        acc_sum[PW-1:thpid_pkg::ACC_W-1] == '1) begin
                        acc_next = acc_sum[thpid_pkg::ACC_W-1:0];
                    end else if (acc_sum[PW-1]) begin
                        acc_next = {1'b1, {(thpid_pkg::ACC_W - 1){1'b0}}};
                    end else begin
                        acc_next = {1'b0, {(thpid_pkg::ACC_W - 1){1'b1}}};
                    end
                end
                mul_a_next = thpid_pkg::MUL_A_W'(err_diff);
                mul_b_next = thpid_pkg::MUL_B_W'(thpid_pkg::RATE_SCALE);
                state_next = ST_R_MUL;
            end
            ST_R_MUL: state_next = ST_R_GO;
            ST_R_GO: begin
                div_go_next  = 1'b1;
                div_num_next = thpid_pkg::DIV_NUM_W'(prod_reg);
                div_den_next = (elapsed_reg == '0) ? thpid_pkg::DIV_DEN_W'(1) : elapsed_reg;
                state_next   = ST_R_DIV;
            end
            ST_R_DIV: begin
                if (div_rsp.done) begin
                    mul_a_next = div_rsp.quo;
                    mul_b_next = $signed({1'b0, gain_d_reg});
                    state_next = ST_D_MUL;
                end
            end
            ST_D_MUL: state_next = ST_SUM;
            ST_SUM: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    out_temp_next = temp_reg;
                    if (pid_sum[PW-1]) begin
                        duty_next = '0;
                    end else if (pid_sum[PW-2:thpid_pkg::DUTY_LSB + thpid_pkg::DUTY_W] != '0) begin
                        duty_next = '1;
                    end else begin
                        duty_next = pid_sum[thpid_pkg::DUTY_LSB + thpid_pkg::DUTY_W - 1:
                                            thpid_pkg::DUTY_LSB];
                    end
                    last_err_next = err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sum_reg      <= '0;
            count_reg    <= '0;
            acc_reg      <= '0;
            last_err_reg <= '0;
            k_reg        <= '0;
            div_go_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            acc_reg      <= acc_next;
            last_err_reg <= last_err_next;
            k_reg        <= k_next;
            div_go_reg   <= div_go_next;
            m_valid_reg  <= m_valid_next;
        end
        elapsed_reg  <= elapsed_next;
        avg_reg      <= avg_next;
        prev_reg     <= prev_next;
        t0_reg       <= t0_next;
        temp_reg     <= temp_next;
        err_reg      <= err_next;
        p_reg        <= p_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        div_num_reg  <= div_num_next;
        div_den_reg  <= div_den_next;
        duty_reg     <= duty_next;
        out_temp_reg <= out_temp_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_duty        = duty_reg;
    assign m_temperature = out_temp_reg;

endmodule

// ===== rtl/thpid_checker.sv =====
`include "assert_macros.svh"

module thpid_checker (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_valid,
    input logic                                    s_ready,
    input logic [thpid_pkg::OP_W-1:0]              s_op,
    input logic                                    m_valid,
    input logic                                    m_ready,
    input logic [thpid_pkg::DUTY_W-1:0]            m_duty,
    input logic signed [thpid_pkg::OUT_TEMP_W-1:0] m_temperature
);

    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_duty) && $stable(m_temperature), "result changed while stalled")

    `ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

    `ASSERT_CLK(a_table_no_result, s_valid && s_ready && s_op == thpid_pkg::OP_TABLE |=> !m_valid || $past(m_valid), "table write produced a result")

    `ASSERT_CLK(a_result_from_step, $rose(m_valid) |-> $past(!s_ready), "result without a control step")

endmodule

bind thermistor_pid_heater_control thpid_checker u_checker (.*);

// ===== test/thermistor_pid_heater_control_checker.sv =====
`timescale 1ns / 100ps

module thermistor_pid_heater_control_checker
    import thpid_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [OP_W-1:0]               s_op,
    input  logic [ENTRY_IDX_W-1:0]        s_entry_index,
    input  logic [ADC_W-1:0]              s_entry_adc,
    input  logic signed [TEMP_W-1:0]      s_entry_temp,
    input  logic [ADC_W-1:0]              s_adc_sample,
    input  logic [ELAPSED_W-1:0]          s_elapsed_ms,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [DUTY_W-1:0]             m_duty,
    input  logic signed [OUT_TEMP_W-1:0]  m_temperature,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            steps_checked
);

    typedef struct packed {
        logic [DUTY_W-1:0]            duty;
        logic signed [OUT_TEMP_W-1:0] temperature;
    } step_result_t;

    step_result_t step_results_q[$];

    logic [ADC_W-1:0]         cal_adc [TABLE_DEPTH_DEF];
    logic signed [TEMP_W-1:0] cal_temp [TABLE_DEPTH_DEF];
    int unsigned              adc_sum;
    int unsigned              adc_count;
    longint                   integ;
    longint                   prev_err;

    logic [SETPOINT_W-1:0] setpoint;
    logic [GAIN_W-1:0]     kp, ki, kd, window;
    logic [COUNT_W-1:0]    entries;

    function automatic longint lookup_temp(int unsigned avg);
        int     n;
        int     k;
        longint a0, a1, t0, t1;
        n = entries;
        if (n < 1) n = 1;
        if (n > TABLE_DEPTH_DEF) n = TABLE_DEPTH_DEF;
        k = 0;
        while (k < n && cal_adc[k] < avg) k++;
        if (k == n) return longint'(cal_temp[n-1]) * 256;
        if (k == 0) return longint'(cal_temp[0]) * 256;
        a0 = cal_adc[k-1];
        a1 = cal_adc[k];
        t0 = cal_temp[k-1];
        t1 = cal_temp[k];
        return t0 * 256 + ((longint'(avg) - a0) * (t1 - t0) * 256) / (a1 - a0);
    endfunction

    task automatic control_step(input logic [ELAPSED_W-1:0] elapsed_ms);
        longint       temp, err, mag, acc, rate, sum, ms;
        step_result_t r;
        temp = lookup_temp(adc_sum / SAMPLES_PER_STEP_DEF);
        adc_sum = 0;
        adc_count = 0;
        err = longint'(setpoint) * 256 - temp;
        mag = err < 0 ? -err : err;
        if (mag < longint'(window)) begin
            acc = integ + longint'(ki) * err;
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            integ = acc;
        end
        ms = (elapsed_ms == 0) ? 1 : longint'(elapsed_ms);
        rate = ((err - prev_err) * 1000) / ms;
        sum = longint'(kp) * err + integ + longint'(kd) * rate;
        if (sum < 0)
            r.duty = '0;
        else if ((sum >>> 16) > 255)
            r.duty = 8'd255;
        else
            r.duty = sum[23:16];
        r.temperature = temp[OUT_TEMP_W-1:0];
        prev_err = err;
        step_results_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        step_result_t want;
        if (!aresetn) begin
            step_results_q.delete();
            adc_sum = 0;
            adc_count = 0;
            integ = 0;
            prev_err = 0;
            setpoint = SETPOINT_RST;
            kp = GAIN_P_RST;
            ki = GAIN_I_RST;
            kd = GAIN_D_RST;
            window = WINDOW_RST;
            entries = COUNT_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_SETPOINT:        setpoint = cfg_data[SETPOINT_W-1:0];
                    REG_GAIN_P:          kp = cfg_data;
                    REG_GAIN_I:          ki = cfg_data;
                    REG_GAIN_D:          kd = cfg_data;
                    REG_INTEGRAL_WINDOW: window = cfg_data;
                    REG_ENTRY_COUNT:     entries = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                steps_checked++;
                if (step_results_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: duty %0d temperature %0d",
                                 m_duty, m_temperature);
                end else begin
                    want = step_results_q.pop_front();
                    if (m_duty !== want.duty || m_temperature !== want.temperature) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: duty exp %0d got %0d, temperature exp %0d got %0d",
                                     want.duty, m_duty, want.temperature, m_temperature);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_op == OP_TABLE) begin
                    cal_adc[s_entry_index] = s_entry_adc;
                    cal_temp[s_entry_index] = s_entry_temp;
                end else begin
                    adc_sum += s_adc_sample;
                    adc_count++;
                    if (adc_count >= SAMPLES_PER_STEP_DEF)
                        control_step(s_elapsed_ms);
                end
            end
        end
        pending = step_results_q.size();
    end

endmodule

// ===== test/thermistor_pid_heater_control_tb.sv =====
`timescale 1ns / 100ps

module thermistor_pid_heater_control_tb;
    import thpid_pkg::*;

    localparam int LIMIT  = 1000000;
    localparam int SETTLE = 300;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [OP_W-1:0]               s_op;
    logic [ENTRY_IDX_W-1:0]        s_entry_index;
    logic [ADC_W-1:0]              s_entry_adc;
    logic signed [TEMP_W-1:0]      s_entry_temp;
    logic [ADC_W-1:0]              s_adc_sample;
    logic [ELAPSED_W-1:0]          s_elapsed_ms;
    logic                          m_valid;
    logic                          m_ready;
    logic [DUTY_W-1:0]             m_duty;
    logic signed [OUT_TEMP_W-1:0]  m_temperature;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    int fail_count, pending, steps_checked;
    int cycles;
    int items_sent;
    int cfg_writes;
    bit burst_mode;
    int stall_left;
    int center;

    thermistor_pid_heater_control uut (.*);

    thermistor_pid_heater_control_checker checker_i (.*);

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (burst_mode) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < 15)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                          : $urandom_range(1, 3);
        end
    end

    function automatic int gap_len();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ENTRY_IDX_W-1:0] idx,
                             input logic [ADC_W-1:0] adc, input logic [TEMP_W-1:0] temp,
                             input logic [ADC_W-1:0] sample, input logic [ELAPSED_W-1:0] ms);
        int gap;
        s_valid <= 1'b1;
        s_op <= op;
        s_entry_index <= idx;
        s_entry_adc <= adc;
        s_entry_temp <= temp;
        s_adc_sample <= sample;
        s_elapsed_ms <= ms;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (items_sent % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_sample(input logic [ADC_W-1:0] sample, input logic [ELAPSED_W-1:0] ms);
        send_item(OP_SAMPLE, ENTRY_IDX_W'($urandom), ADC_W'($urandom), TEMP_W'($urandom),
                  sample, ms);
    endtask

    task automatic send_entry(input logic [ENTRY_IDX_W-1:0] idx, input logic [ADC_W-1:0] adc,
                              input logic [TEMP_W-1:0] temp);
        send_item(OP_TABLE, idx, adc, temp, ADC_W'($urandom), ELAPSED_W'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_loop(input int sp, input int gp, input int gi, input int gd,
                            input int win, input int cnt);
        drain();
        write_reg(REG_SETPOINT, CFG_DATA_W'(sp));
        write_reg(REG_GAIN_P, CFG_DATA_W'(gp));
        write_reg(REG_GAIN_I, CFG_DATA_W'(gi));
        write_reg(REG_GAIN_D, CFG_DATA_W'(gd));
        write_reg(REG_INTEGRAL_WINDOW, CFG_DATA_W'(win));
        write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(cnt));
    endtask

    task automatic load_table(input bit descending);
        int a, t;
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
            a = i * 64 + $urandom_range(0, 63);
            t = -128 + i * 10 + $urandom_range(0, 9);
            if (descending) a = 4095 - a;
            send_entry(ENTRY_IDX_W'(i), ADC_W'(a), TEMP_W'(t));
        end
    endtask

    function automatic int pick_elapsed();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return 65535;
        if (r < 5) return $urandom_range(0, 65535);
        return $urandom_range(1, 2000);
    endfunction

    task automatic random_run(input int count);
        int r, s;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_entry(ENTRY_IDX_W'($urandom), ADC_W'($urandom), TEMP_W'($urandom));
            end else begin
                if (r < 8) center = $urandom_range(0, 4095);
                if (r < 12)
                    s = ($urandom_range(0, 1) == 0) ? 0 : 4095;
                else begin
                    s = center + $urandom_range(0, 200) - 100;
                    if (s < 0) s = 0;
                    if (s > 4095) s = 4095;
                end
                send_sample(ADC_W'(s), ELAPSED_W'(pick_elapsed()));
            end
        end
    endtask

    initial begin
        items_sent = 0;
        cfg_writes = 0;
        burst_mode = 0;
        center = 2048;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_op <= OP_SAMPLE;
        s_entry_index <= '0;
        s_entry_adc <= '0;
        s_entry_temp <= '0;
        s_adc_sample <= '0;
        s_elapsed_ms <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SETPOINT;
        cfg_data <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_table(1'b0);
        // below first entry, zero elapsed time
        repeat (15) send_sample(ADC_W'(0), ELAPSED_W'(123));
        send_sample(ADC_W'(0), ELAPSED_W'(0));
        // above last entry, longest elapsed time
        repeat (15) send_sample(ADC_W'(4095), ELAPSED_W'(7));
        send_sample(ADC_W'(4095), ELAPSED_W'(65535));

        set_loop(255, 65535, 65535, 65535, 65535, 1);
        random_run(150);
        set_loop(0, 0, 0, 0, 0, 64);
        random_run(150);
        set_loop($urandom_range(0, 255), $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
        random_run(150);
        set_loop($urandom_range(0, 255), $urandom_range(0, 4000), $urandom_range(0, 400),
                 $urandom_range(0, 2000), $urandom_range(0, 4096), 127);
        random_run(150);
        drain();
        load_table(1'b1);
        set_loop($urandom_range(0, 255), $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(1, 64));
        random_run(150);
        drain();
        load_table(1'b0);
        set_loop(70, 2330, 77, 461, 768, 64);
        random_run(200);

        drain();
        $display("sent %0d items and %0d register writes, checked %0d control steps",
                 items_sent, cfg_writes, steps_checked);
        $display("covered table extremes, descending table, entry count 0/1/64/127, gain extremes");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/thpid_pkg.sv
rtl/thpid_div.sv
rtl/thermistor_pid_heater_control.sv
rtl/thpid_checker.sv
test/thermistor_pid_heater_control_checker.sv
test/thermistor_pid_heater_control_tb.sv
